### rtl/core/bsfb_pkg.sv
// shared types and constants of the byte-stuffed frame builder
// no dependencies; the front end, queue, back end and top level import this package
package bsfb_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_FLAG   = 8'h5E;
	localparam logic [7:0] ESC_ESC    = 8'h5D;
	localparam logic [7:0] CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] CTRL_SEQ1  = 8'h02;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	// one classified payload beat, queued between front and back
	typedef struct packed {
		logic       hdr;   // first byte of a frame: header goes out first
		logic [7:0] addr;  // address field captured at classification
		logic       seq;   // sequence bit for the control byte
		logic [7:0] data;  // unstuffed payload byte
		logic       last;  // final byte: check and closing flag follow
		logic [7:0] chk;   // xor check over the frame, valid with last
	} cmd_t;

	// emission phase of the back end
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_FLAG0,
		PH_ADDR,
		PH_CTRL,
		PH_HCHK,
		PH_DATA,
		PH_DATA_ESC,
		PH_CHK,
		PH_CHK_ESC,
		PH_FLAG1
	} phase_t;

endpackage

### rtl/core/bsfb_in_if.sv
// payload input channel of the byte-stuffed frame builder
// no dependencies
interface bsfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

### rtl/core/bsfb_out_if.sv
// line byte output channel of the byte-stuffed frame builder
// no dependencies
interface bsfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       frame_end;

	modport source(output valid, out_byte, last_of_run, frame_end, input ready);
	modport sink(input valid, out_byte, last_of_run, frame_end, output ready);
endinterface

### rtl/core/bsfb_cfg_if.sv
// address register write channel of the byte-stuffed frame builder
// no dependencies
interface bsfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] address_byte;

	modport source(output valid, address_byte, input ready);
	modport sink(input valid, address_byte, output ready);
endinterface

### rtl/core/bsfb_front.sv
// front end: address register, frame state and classification of payload beats
// depends on bsfb_pkg, bsfb_in_if, bsfb_cfg_if
module bsfb_front (
	input  logic            clk,
	input  logic            arst_n,
	bsfb_cfg_if.sink        cfg,
	bsfb_in_if.sink         pay_in,
	output bsfb_pkg::cmd_t  push_cmd,
	output logic            push_valid,
	input  logic            push_ready
);
	import bsfb_pkg::*;

	logic [7:0] addr_q;
	logic       in_frame_q;
	logic       seq_q;
	logic [7:0] chk_q;
	logic       accept;
	logic [7:0] chk_next;

	assign cfg.ready    = 1'b1;
	assign pay_in.ready = push_ready;
	assign push_valid   = pay_in.valid;
	assign accept       = pay_in.valid && push_ready;

	// check restarts at the first byte of each frame
	assign chk_next = (in_frame_q ? chk_q : 8'h00) ^ pay_in.data_byte;

	always_comb begin
		push_cmd.hdr  = !in_frame_q;
		push_cmd.addr = addr_q;
		push_cmd.seq  = seq_q;
		push_cmd.data = pay_in.data_byte;
		push_cmd.last = pay_in.last_byte;
		push_cmd.chk  = chk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg.valid) begin
			addr_q <= cfg.address_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			seq_q      <= 1'b0;
			chk_q      <= 8'h00;
		end else if (accept) begin
			if (pay_in.last_byte) begin
				in_frame_q <= 1'b0;
				seq_q      <= !seq_q;
				chk_q      <= 8'h00;
			end else begin
				in_frame_q <= 1'b1;
				chk_q      <= chk_next;
			end
		end
	end

endmodule

### rtl/core/bsfb_queue.sv
// short command queue between front and back end
// depends on bsfb_pkg
module bsfb_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bsfb_pkg::cmd_t  push_cmd,
	input  logic            push_valid,
	output logic            push_ready,
	output bsfb_pkg::cmd_t  head_cmd,
	output logic            head_valid,
	input  logic            head_pop
);
	import bsfb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop without push did not drain an entry");

endmodule

### rtl/core/bsfb_back.sv
// back end: emits a queued beat: header if first, stuffed payload, trailer if last
// depends on bsfb_pkg, bsfb_out_if
module bsfb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bsfb_pkg::cmd_t  head_cmd,
	input  logic            head_valid,
	output logic            head_pop,
	bsfb_out_if.source      line_out
);
	import bsfb_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	phase_t     cur;
	phase_t     nxt;
	logic       load;
	logic       done;
	logic       fend;
	logic [7:0] obyte;
	logic [7:0] ctrl;
	logic       data_spec;
	logic       chk_spec;

	logic       ov_q;
	logic [7:0] obyte_q;
	logic       lor_q;
	logic       fend_q;

	assign ctrl      = head_cmd.seq ? CTRL_SEQ1 : CTRL_SEQ0;
	assign data_spec = (head_cmd.data == FLAG_BYTE) || (head_cmd.data == ESC_BYTE);
	assign chk_spec  = (head_cmd.chk == FLAG_BYTE) || (head_cmd.chk == ESC_BYTE);
	assign load      = head_valid && (!ov_q || line_out.ready);
	assign head_pop  = load && done;

	always_comb begin
		cur = phase_q;
		if (phase_q == PH_IDLE) begin
			cur = head_cmd.hdr ? PH_FLAG0 : PH_DATA;
		end
		nxt   = PH_IDLE;
		done  = 1'b0;
		fend  = 1'b0;
		obyte = FLAG_BYTE;
		case (cur)
			PH_FLAG0: begin
				obyte = FLAG_BYTE;
				nxt   = PH_ADDR;
			end
			PH_ADDR: begin
				obyte = head_cmd.addr;
				nxt   = PH_CTRL;
			end
			PH_CTRL: begin
				obyte = ctrl;
				nxt   = PH_HCHK;
			end
			PH_HCHK: begin
				obyte = head_cmd.addr ^ ctrl;
				nxt   = PH_DATA;
			end
			PH_DATA: begin
				if (data_spec) begin
					obyte = ESC_BYTE;
					nxt   = PH_DATA_ESC;
				end else begin
					obyte = head_cmd.data;
					nxt   = PH_CHK;
					done  = !head_cmd.last;
				end
			end
			PH_DATA_ESC: begin
				obyte = (head_cmd.data == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
				nxt   = PH_CHK;
				done  = !head_cmd.last;
			end
			PH_CHK: begin
				if (chk_spec) begin
					obyte = ESC_BYTE;
					nxt   = PH_CHK_ESC;
				end else begin
					obyte = head_cmd.chk;
					nxt   = PH_FLAG1;
				end
			end
			PH_CHK_ESC: begin
				obyte = (head_cmd.chk == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
				nxt   = PH_FLAG1;
			end
			PH_FLAG1: begin
				obyte = FLAG_BYTE;
				fend  = 1'b1;
				done  = 1'b1;
			end
			default: begin
				obyte = FLAG_BYTE;
				done  = 1'b1;
			end
		endcase
		phase_d = phase_q;
		if (load) begin
			phase_d = done ? PH_IDLE : nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (line_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= obyte;
			lor_q   <= done;
			fend_q  <= fend;
		end
	end

	assign line_out.valid       = ov_q;
	assign line_out.out_byte    = obyte_q;
	assign line_out.last_of_run = lor_q;
	assign line_out.frame_end   = fend_q;

	a_frame_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && fend_q) |-> (obyte_q == FLAG_BYTE && lor_q))
		else $error("frame end beat is not a final closing flag");

	a_mid_cmd_head: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> head_valid)
		else $error("command left the queue before its last beat");

	a_escape_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && cur == PH_DATA && data_spec) |=> (phase_q == PH_DATA_ESC))
		else $error("escaped payload byte lost its second beat");

endmodule

### rtl/core/byte_stuffed_frame_builder.sv
// top level of the byte-stuffed frame builder: front end, command queue, back end
// depends on bsfb_pkg, bsfb_in_if, bsfb_out_if, bsfb_cfg_if, bsfb_front, bsfb_queue, bsfb_back

// Builds HDLC-style information frames from payload bytes. The first payload
// beat of a frame is preceded by flag 0x7E, the address register, the control
// byte (0x00 or 0x02 from the sequence bit) and their xor; payload 0x7E and
// 0x7D are escaped as 0x7D 0x5E and 0x7D 0x5D; the final beat is followed by
// the escaped xor check and a closing flag marked with frame_end. line_out
// moves one byte per cycle while ready and a beat is queued; one payload
// beat gives 1 to 9 line bytes: 4 header bytes on the first beat, 1 or 2
// for the payload byte, 1 or 2 for the check and 1 for the flag on the last
// beat, about 2 per beat for stuffed-heavy data. The front end takes a
// payload beat every cycle while the QUEUE_DEPTH-entry command queue has
// room; the first line byte of a beat passes a queue entry, then the output
// register. The address register can be written any cycle and is sampled
// when a frame's first beat is accepted. No start-up pass after reset.
module byte_stuffed_frame_builder #(
	parameter int QUEUE_DEPTH = 4   // commands buffered between front and back, 2 or more
) (
	input  logic        clk,
	input  logic        arst_n,
	bsfb_cfg_if.sink    cfg,
	bsfb_in_if.sink     pay_in,
	bsfb_out_if.source  line_out
);
	import bsfb_pkg::*;

	// classified beat from the front end
	cmd_t push_cmd;
	logic push_valid;
	logic push_ready;

	// head of the queue as seen by the back end
	cmd_t head_cmd;
	logic head_valid;
	logic head_pop;

	// address register, frame state, running check
	bsfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pay_in     (pay_in),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// decouples payload intake from line emission
	bsfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	// byte sequencer with registered line output
	bsfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.line_out   (line_out)
	);

endmodule
